FILE: src/hbp_pkg.sv
// Package with the shared types and constants of the Huffman bit packer.
`timescale 1ns / 1ps
`default_nettype none

package hbp_pkg;

    // Field widths fixed by the item formats.
    localparam int BYTE_W = 8;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int FILL_W = 3;
    localparam int LBF_W  = 4;

    // Defaults for the top-level parameters.
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOL_COUNT_DEF = 256;

    // Depths of the job queue and the result queue.
    localparam int JOB_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // Item modes.
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_ENCODE = 1'b1;

    // One input item.
    typedef struct packed {
        logic              mode;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic              is_last;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_trailer;
        logic              run_end;
    } t_out_item;

    // One code table entry.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_entry;

    // One packing job: the code left-aligned, its length and the last flag.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_job;

    // Packer states.
    typedef enum logic [1:0] {
        PK_IDLE,
        PK_JOB,
        PK_FLUSH,
        PK_TRAILER
    } t_pack_state;

endpackage

`default_nettype wire

FILE: src/hbp_fifo.sv
// Small synchronous queue used between the packer stages and at the result side.
`timescale 1ns / 1ps
`default_nettype none

module hbp_fifo #(
    parameter type t_item = logic,
    parameter int  DEPTH  = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_item      o_data,
    output logic       o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    // Status flags and the transfers that take place this cycle.
    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    // Pointer and count updates, wrapping at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/hbp_front.sv
// Front end: code table, lookup of each source byte and job formation.
`timescale 1ns / 1ps
`default_nettype none

module hbp_front
    import hbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    input  wire t_in_item i_in_item,
    output logic          full,
    output logic          o_job_push,
    output t_job          o_job,
    input  wire logic     i_job_full
);

    localparam int ADDR_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    t_entry            r_table [SYMBOL_COUNT];
    t_entry            r_rd_data;
    logic              r_rd_valid, n_rd_valid;
    logic              r_rd_last;
    logic              r_rd_hit;
    logic              w_accept;
    logic              w_in_range;
    logic [ADDR_W-1:0] w_addr;
    logic [LEN_W-1:0]  w_len;

    // An item waits only while a looked-up job cannot enter the queue.
    assign full       = r_rd_valid && i_job_full;
    assign w_accept   = push && !full;
    assign w_in_range = ({1'b0, i_in_item.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign w_addr     = i_in_item.symbol[ADDR_W-1:0];
    assign o_job_push = r_rd_valid && !i_job_full;

    // Table write on load items, registered read on encode items.
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in_item.mode == MODE_LOAD) && w_in_range) begin
            r_table[w_addr] <= '{code: i_in_item.code_bits, len: i_in_item.code_length};
        end
        if (w_accept && (i_in_item.mode == MODE_ENCODE)) begin
            r_rd_data <= r_table[w_addr];
            r_rd_last <= i_in_item.is_last;
            r_rd_hit  <= w_in_range;
        end
    end

    // The lookup stage holds its job until the queue takes it.
    always_comb begin
        n_rd_valid = r_rd_valid;
        if (w_accept && (i_in_item.mode == MODE_ENCODE)) begin
            n_rd_valid = 1'b1;
        end else if (o_job_push) begin
            n_rd_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= n_rd_valid;
        end
    end

    // Saturate the length and left-align the code; the shift drops bits above the length.
    always_comb begin
        if (!r_rd_hit) begin
            w_len = '0;
        end else if (r_rd_data.len > LEN_W'(LEN_LIMIT)) begin
            w_len = LEN_W'(LEN_LIMIT);
        end else begin
            w_len = r_rd_data.len;
        end
        o_job.code = r_rd_data.code << (LEN_W'(CODE_W) - w_len);
        o_job.len  = w_len;
        o_job.last = r_rd_last;
    end

endmodule

`default_nettype wire

FILE: src/hbp_back.sv
// Back end: packs left-aligned codes into bytes and emits flush and trailer bytes.
`timescale 1ns / 1ps
`default_nettype none

module hbp_back
    import hbp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_job  i_job,
    input  wire logic  i_job_empty,
    output logic       o_job_pop,
    output logic       o_out_push,
    output t_out_item  o_out_data,
    input  wire logic  i_out_full
);

    t_pack_state       r_state, n_state;
    logic [CODE_W-1:0] r_code, n_code;
    logic [LEN_W-1:0]  r_rem, n_rem;
    logic              r_last, n_last;
    logic [BYTE_W-1:0] r_pack_byte, n_pack_byte;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [LBF_W-1:0]  r_lbf, n_lbf;

    logic [LEN_W-1:0]  w_sum;
    logic [BYTE_W-1:0] w_cand;
    logic [LBF_W-1:0]  w_take;
    logic              w_finish;
    logic              w_to_flush;
    logic              w_to_trailer;
    logic              w_load;

    // Bits pending plus bits left, the byte they would form, and the bits one byte takes.
    assign w_sum  = LEN_W'(r_fill) + r_rem;
    assign w_cand = r_pack_byte | (r_code[CODE_W-1 -: BYTE_W] >> r_fill);
    assign w_take = LBF_W'(BYTE_W) - LBF_W'(r_fill);
    assign w_load = ((r_state == PK_IDLE) || w_finish) && !i_job_empty;
    assign o_job_pop = w_load;

    // Datapath and result transfers for the current step.
    always_comb begin
        n_code       = r_code;
        n_rem        = r_rem;
        n_last       = r_last;
        n_pack_byte  = r_pack_byte;
        n_fill       = r_fill;
        n_lbf        = r_lbf;
        o_out_push   = 1'b0;
        o_out_data   = '{out_byte: w_cand, is_trailer: 1'b0, run_end: 1'b0};
        w_finish     = 1'b0;
        w_to_flush   = 1'b0;
        w_to_trailer = 1'b0;
        case (r_state)
            PK_JOB: begin
                if (w_sum >= LEN_W'(BYTE_W)) begin
                    if (!i_out_full) begin
                        // The byte ends a non-last item's results when fewer than a byte's bits remain.
                        o_out_push         = 1'b1;
                        o_out_data.run_end = !r_last && (w_sum < LEN_W'(2 * BYTE_W));
                        n_code             = r_code << w_take;
                        n_rem              = w_sum - LEN_W'(BYTE_W);
                        n_pack_byte        = '0;
                        n_fill             = '0;
                        n_lbf              = LBF_W'(BYTE_W);
                        if (w_sum == LEN_W'(BYTE_W)) begin
                            w_to_flush = r_last;
                            w_finish   = !r_last;
                        end
                    end
                end else begin
                    n_pack_byte = w_cand;
                    n_fill      = w_sum[FILL_W-1:0];
                    n_rem       = '0;
                    w_to_flush  = r_last;
                    w_finish    = !r_last;
                end
            end
            PK_FLUSH: begin
                if (!i_out_full) begin
                    o_out_push = 1'b1;
                    if (r_fill != '0) begin
                        o_out_data.out_byte = r_pack_byte;
                        n_lbf               = LBF_W'(r_fill);
                        n_fill              = '0;
                        n_pack_byte         = '0;
                        w_to_trailer        = 1'b1;
                    end else begin
                        o_out_data = '{out_byte: BYTE_W'(r_lbf), is_trailer: 1'b1,
                                       run_end: 1'b1};
                        n_lbf      = '0;
                        w_finish   = 1'b1;
                    end
                end
            end
            PK_TRAILER: begin
                if (!i_out_full) begin
                    o_out_push = 1'b1;
                    o_out_data = '{out_byte: BYTE_W'(r_lbf), is_trailer: 1'b1,
                                   run_end: 1'b1};
                    n_lbf      = '0;
                    w_finish   = 1'b1;
                end
            end
            default: begin
            end
        endcase
        // The next job enters as soon as the current one is done.
        if (w_load) begin
            n_code = i_job.code;
            n_rem  = i_job.len;
            n_last = i_job.last;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        if (w_load) begin
            n_state = PK_JOB;
        end else if (w_finish) begin
            n_state = PK_IDLE;
        end else if (w_to_flush) begin
            n_state = PK_FLUSH;
        end else if (w_to_trailer) begin
            n_state = PK_TRAILER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= PK_IDLE;
            r_pack_byte <= '0;
            r_fill      <= '0;
            r_lbf       <= '0;
        end else begin
            r_state     <= n_state;
            r_pack_byte <= n_pack_byte;
            r_fill      <= n_fill;
            r_lbf       <= n_lbf;
        end
    end

    // Job payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_rem  <= n_rem;
        r_last <= n_last;
    end

endmodule

`default_nettype wire

FILE: src/huffman_bit_packer_unit.sv
// Top level of the Huffman bit packer: lookup front end, job queue, packer and result queue.
//
//   Channel  | Handshake                      | Payload
//   ---------+--------------------------------+------------------------
//   input    | push / full, take: push & !full | i_in_item  (t_in_item)
//   result   | empty / pop, take: pop & !empty | o_out_item (t_out_item)
//
// A load item writes the code table. An encode item passes through the registered table read,
// then the single byte-wide packing step emits its bytes one at a time, holding while the result
// queue is full, and takes one more step when the code leaves bits pending or emits no byte.
// The job queue lets lookups run ahead. Reset is synchronous and active low; the
// code table is not cleared. Either side may stall without losing items; full rises
// when the job queue is full and the lookup stage holds a job.
`timescale 1ns / 1ps
`default_nettype none

module huffman_bit_packer_unit
    import hbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    input  wire t_in_item i_in_item,
    output logic          full,
    output logic          empty,
    input  wire logic     pop,
    output t_out_item     o_out_item
);

    t_job      w_job_in;
    t_job      w_job_out;
    logic      w_job_push;
    logic      w_job_full;
    logic      w_job_pop;
    logic      w_job_empty;
    t_out_item w_out_data;
    logic      w_out_push;
    logic      w_out_full;

    // Table lookup and job formation.
    hbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_in_item  (i_in_item),
        .full       (full),
        .o_job_push (w_job_push),
        .o_job      (w_job_in),
        .i_job_full (w_job_full)
    );

    // Queue of jobs between lookup and packing.
    hbp_fifo #(
        .t_item (t_job),
        .DEPTH  (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_empty (w_job_empty)
    );

    // Bit packer.
    hbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job_out),
        .i_job_empty (w_job_empty),
        .o_job_pop   (w_job_pop),
        .o_out_push  (w_out_push),
        .o_out_data  (w_out_data),
        .i_out_full  (w_out_full)
    );

    // Result queue toward the consumer.
    hbp_fifo #(
        .t_item (t_out_item),
        .DEPTH  (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_data),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (o_out_item),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

FILE: sim/huffman_bit_packer_unit_tb.sv
// Self-checking testbench for the Huffman bit packer: directed and random streams.
`timescale 1ns / 1ps

module huffman_bit_packer_unit_tb;
    import hbp_pkg::*;

    localparam int MAX_LEN   = MAX_CODE_LEN_DEF;
    localparam int SYM_COUNT = SYMBOL_COUNT_DEF;
    localparam int RANDOM_ITEMS = 460;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int SETTLE_CYCLES = 20;

    // One pending input transfer; a marked item waits until all output bytes have come.
    typedef struct {
        t_in_item item;
        bit       wait_drain;
    } t_stim;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    t_in_item  i_in_item = '0;
    logic      full;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_out_item;

    t_stim     stim_q[$];
    int        next_idx = 0;
    t_out_item expected_bytes[$];
    int        errors = 0;

    // Idle percentages per phase: none, sender only, receiver only, both lightly.
    int send_gap_pct[4] = '{0, 45, 0, 9};
    int recv_stall_pct[4] = '{0, 0, 45, 9};
    int phase;

    // Shadow copy of the code table and of the packing state.
    logic [CODE_W-1:0] shadow_code[SYM_COUNT];
    logic [LEN_W-1:0]  shadow_len[SYM_COUNT];
    logic [7:0]        acc_byte = '0;
    int                acc_fill = 0;
    logic [3:0]        last_fill = '0;

    // Stimulus bookkeeping: which table entries are safe to encode.
    bit                entry_loaded[SYM_COUNT];
    logic [SYM_W-1:0]  loaded_syms[$];

    huffman_bit_packer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_in_item  (i_in_item),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Update the shadow state for one accepted item and queue the bytes it must produce.
    function automatic void pack_item(t_in_item it);
        t_out_item produced[$];
        t_out_item res;
        int        eff_len;
        logic [CODE_W-1:0] code;

        if (it.mode == MODE_LOAD) begin
            shadow_code[it.symbol] = it.code_bits;
            shadow_len[it.symbol]  = it.code_length;
            return;
        end

        eff_len = shadow_len[it.symbol];
        if (eff_len > MAX_LEN) eff_len = MAX_LEN;
        if (eff_len > CODE_W) eff_len = CODE_W;
        code = shadow_code[it.symbol];

        // Append the code MSB first; bits above the length are never read.
        for (int b = eff_len - 1; b >= 0; b--) begin
            acc_byte[7 - acc_fill] = code[b];
            acc_fill++;
            if (acc_fill == 8) begin
                res = '{out_byte: acc_byte, is_trailer: 1'b0, run_end: 1'b0};
                produced.push_back(res);
                last_fill = 4'd8;
                acc_byte  = '0;
                acc_fill  = 0;
            end
        end

        // End of stream: flush the partial byte, then the valid-bit count.
        if (it.is_last) begin
            if (acc_fill > 0) begin
                res = '{out_byte: acc_byte, is_trailer: 1'b0, run_end: 1'b0};
                produced.push_back(res);
                last_fill = 4'(acc_fill);
                acc_byte  = '0;
                acc_fill  = 0;
            end
            res = '{out_byte: {4'd0, last_fill}, is_trailer: 1'b1, run_end: 1'b0};
            produced.push_back(res);
            last_fill = '0;
        end

        if (produced.size() > 0) produced[produced.size() - 1].run_end = 1'b1;
        foreach (produced[i]) expected_bytes.push_back(produced[i]);
    endfunction

    function automatic void add_load(logic [SYM_W-1:0] sym, logic [CODE_W-1:0] code,
                                     logic [LEN_W-1:0] len, logic last);
        t_stim s;
        s.item = '{mode: MODE_LOAD, symbol: sym, code_bits: code,
                   code_length: len, is_last: last};
        s.wait_drain = 1'b0;
        stim_q.push_back(s);
        if (!entry_loaded[sym]) begin
            entry_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endfunction

    function automatic void add_encode(logic [SYM_W-1:0] sym, logic last, bit drain);
        t_stim s;
        s.item = '{mode: MODE_ENCODE, symbol: sym, code_bits: $urandom,
                   code_length: LEN_W'($urandom), is_last: last};
        s.wait_drain = drain;
        stim_q.push_back(s);
    endfunction

    // Driver: presents items from the stimulus queue and predicts on each transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                pack_item(i_in_item);
                next_idx++;
            end
            phase = (next_idx / ITEMS_PER_PHASE) % 4;
            if (push && full) begin
                // Hold the item until the block takes it.
            end else if (next_idx < stim_q.size() &&
                         !(stim_q[next_idx].wait_drain && expected_bytes.size() != 0) &&
                         $urandom_range(99) >= send_gap_pct[phase]) begin
                push      <= 1'b1;
                i_in_item <= stim_q[next_idx].item;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: checks each output transfer against the oldest expected byte.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected output: out_byte %0h is_trailer %0b run_end %0b",
                           o_out_item.out_byte, o_out_item.is_trailer, o_out_item.run_end);
                    errors++;
                end else begin
                    if (o_out_item.out_byte !== expected_bytes[0].out_byte) begin
                        $error("out_byte: expected %0h, got %0h",
                               expected_bytes[0].out_byte, o_out_item.out_byte);
                        errors++;
                    end
                    if (o_out_item.is_trailer !== expected_bytes[0].is_trailer) begin
                        $error("is_trailer: expected %0b, got %0b",
                               expected_bytes[0].is_trailer, o_out_item.is_trailer);
                        errors++;
                    end
                    if (o_out_item.run_end !== expected_bytes[0].run_end) begin
                        $error("run_end: expected %0b, got %0b",
                               expected_bytes[0].run_end, o_out_item.run_end);
                        errors++;
                    end
                    void'(expected_bytes.pop_front());
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct[(next_idx / ITEMS_PER_PHASE) % 4]);
        end
    end

    // Stimulus generation, reset, and end of run.
    initial begin
        int               pick;
        logic [LEN_W-1:0] len;
        bit               want_load;

        // Directed loads: zero length, full 32-bit code, masked upper bits,
        // saturated length, and a load that carries the last flag.
        add_load(8'h00, 32'hFFFF_FFFF, 6'd0, 1'b1);
        add_load(8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b0);
        add_load(8'h01, 32'hAAAA_AAA9, 6'd1, 1'b0);
        add_load(8'h02, 32'hA5A5_A5A5, 6'd63, 1'b0);
        add_load(8'h03, 32'h0000_007F, 6'd7, 1'b0);
        add_load(8'h80, 32'h0000_0005, 6'd3, 1'b0);
        add_load(8'h55, 32'h0000_2AAA, 6'd14, 1'b0);
        add_load(8'h7F, 32'h0000_0000, 6'd32, 1'b0);

        // Directed encodes; the partial-byte flush waits until earlier results have drained.
        add_encode(8'h00, 1'b1, 1'b0);  // empty stream with a zero-length last symbol
        add_encode(8'hFF, 1'b0, 1'b0);
        add_encode(8'hFF, 1'b1, 1'b0);  // nothing pending at the flush
        add_encode(8'h80, 1'b1, 1'b1);  // partial byte flushed
        add_encode(8'h03, 1'b0, 1'b0);
        add_encode(8'hFF, 1'b1, 1'b0);  // seven pending bits plus a 32-bit code
        add_encode(8'h01, 1'b0, 1'b0);
        add_encode(8'h00, 1'b1, 1'b0);  // zero-length last symbol with bits pending
        add_encode(8'h02, 1'b1, 1'b0);  // saturated length
        add_encode(8'h7F, 1'b0, 1'b0);
        add_encode(8'h55, 1'b0, 1'b0);
        add_encode(8'h80, 1'b0, 1'b0);
        add_encode(8'h01, 1'b1, 1'b0);

        // Random streams: mostly encodes of loaded symbols, with table reloads mixed in.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            want_load = (loaded_syms.size() < 24) ? ($urandom_range(99) < 40)
                                                  : ($urandom_range(99) < 15);
            if (want_load) begin
                pick = $urandom_range(99);
                if (pick < 5)       len = 6'd0;
                else if (pick < 75) len = LEN_W'($urandom_range(8, 1));
                else if (pick < 90) len = LEN_W'($urandom_range(32, 9));
                else                len = LEN_W'($urandom_range(63, 33));
                add_load(SYM_W'($urandom), $urandom, len, 1'($urandom));
            end else begin
                add_encode(loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                           ($urandom_range(7) == 0), (k % 150 == 0));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (next_idx < stim_q.size()) @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("huffman_bit_packer_unit_tb: done, clean");
        end else begin
            $display("huffman_bit_packer_unit_tb: done, errors");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #4_000_000;
        $display("huffman_bit_packer_unit_tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
src/hbp_pkg.sv
src/hbp_fifo.sv
src/hbp_front.sv
src/hbp_back.sv
src/huffman_bit_packer_unit.sv
sim/huffman_bit_packer_unit_tb.sv
